FILE: hw/rtl/rbsr_pkg.sv
// Package for the rod bank slew and reactivity core.
// Holds widths, codes and the queue item type shared by the front, back and top.
// Depends on nothing.
package rbsr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int POS_W = FRAC_BITS + 1;
	localparam logic [POS_W-1:0] ONE = POS_W'(1) << FRAC_BITS;
	localparam int NBANKS = 4;
	localparam int BANK_W = 2;
	localparam int KIND_W = 3;
	localparam int ELAPSED_W = 10;
	localparam int STEP_W = 17;
	localparam int WORTH_W = 24;
	localparam int MASK_W = 4;
	localparam int REACT_W = 27;
	localparam int TOTAL_W = 19;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int QUEUE_DEPTH = 2;
	localparam int INITIAL_MANUAL_DEF = 32768;

	localparam logic [KIND_W-1:0] KIND_SET = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SCRAM = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_TICK = 3'd3;

	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCRAM_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WORTH_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WORTH_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WORTH_AUTO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WORTH_EMER = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TIP_WORTH = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DISP_MASK = 3'd7;

	typedef enum logic [2:0] {
		OP_SET,
		OP_SCRAM,
		OP_RELEASE,
		OP_TICK,
		OP_QUERY
	} op_t;

	typedef struct packed {
		op_t op;
		logic [BANK_W-1:0] bank;
		logic [POS_W-1:0] frac;
		logic [ELAPSED_W-1:0] elapsed;
	} item_t;

endpackage

FILE: hw/rtl/rbsr_front.sv
// Front end of the rod bank core: accepts requests, classifies them and queues them.
// Uses rbsr_pkg for the item type and codes.
module rbsr_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [rbsr_pkg::KIND_W-1:0] kind,
	input  logic [rbsr_pkg::BANK_W-1:0] bank,
	input  logic [rbsr_pkg::POS_W-1:0] target_fraction,
	input  logic [rbsr_pkg::ELAPSED_W-1:0] elapsed,
	output logic q_valid,
	output rbsr_pkg::item_t q_item,
	input  logic q_pop
);
	localparam int PTR_W = $clog2(rbsr_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(rbsr_pkg::QUEUE_DEPTH + 1);

	rbsr_pkg::item_t mem_q [rbsr_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	rbsr_pkg::item_t new_item;
	logic push;

	always_comb begin
		case (kind)
			rbsr_pkg::KIND_SET: new_item.op = rbsr_pkg::OP_SET;
			rbsr_pkg::KIND_SCRAM: new_item.op = rbsr_pkg::OP_SCRAM;
			rbsr_pkg::KIND_RELEASE: new_item.op = rbsr_pkg::OP_RELEASE;
			rbsr_pkg::KIND_TICK: new_item.op = rbsr_pkg::OP_TICK;
			default: new_item.op = rbsr_pkg::OP_QUERY;
		endcase
		new_item.bank = bank;
		new_item.frac = (target_fraction > rbsr_pkg::ONE) ? rbsr_pkg::ONE : target_fraction;
		new_item.elapsed = elapsed;
	end

	assign in_stall = (count_q == CNT_W'(rbsr_pkg::QUEUE_DEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (count_q != '0);
	assign q_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(rbsr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(rbsr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(rbsr_pkg::QUEUE_DEPTH)) else $error("queue overfilled");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> count_q == $past(count_q) + 1'b1) else $error("count lost a push");
`endif

endmodule

FILE: hw/rtl/rbsr_back.sv
// Back end of the rod bank core: applies queued items to the rod state and
// evaluates reactivity through one shared multiplier. Uses rbsr_pkg.
module rbsr_back #(
	parameter int INITIAL_MANUAL = rbsr_pkg::INITIAL_MANUAL_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [rbsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbsr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic q_valid,
	input  rbsr_pkg::item_t q_item,
	output logic q_pop,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [rbsr_pkg::REACT_W-1:0] reactivity,
	output logic [rbsr_pkg::TOTAL_W-1:0] inserted_total,
	output logic [rbsr_pkg::POS_W-1:0] bank_position,
	output logic [rbsr_pkg::POS_W-1:0] bank_target,
	output logic scram_active
);
	localparam int F = rbsr_pkg::FRAC_BITS;
	localparam int PW = rbsr_pkg::POS_W;
	localparam int WW = rbsr_pkg::WORTH_W;
	localparam int NB = rbsr_pkg::NBANKS;
	localparam int A_W = WW + 1;
	localparam int B_W = PW + 2;
	localparam int P_W = A_W + B_W;
	localparam int TERM_W = P_W - F;
	localparam int ACC_W = rbsr_pkg::REACT_W + 3;
	localparam int TRAV_W = rbsr_pkg::STEP_W + rbsr_pkg::ELAPSED_W;
	localparam int D_W = TRAV_W + 1;
	localparam logic [PW-1:0] MAN_INIT =
		(INITIAL_MANUAL > (1 << F)) ? PW'(1 << F) : PW'(INITIAL_MANUAL);
	localparam logic [PW-1:0] HALF = PW'(1 << (F - 1));
	localparam logic signed [ACC_W-1:0] R_MAX = ACC_W'((1 << (rbsr_pkg::REACT_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] R_MIN = -ACC_W'(1 << (rbsr_pkg::REACT_W - 1));

	localparam logic [2:0] PH_SQ = 3'd0;
	localparam logic [2:0] PH_SMOOTH = 3'd1;
	localparam logic [2:0] PH_WORTH = 3'd2;
	localparam logic [2:0] PH_COM = 3'd3;
	localparam logic [2:0] PH_COM2 = 3'd4;
	localparam logic [2:0] PH_TIP = 3'd5;
	localparam logic [2:0] PH_DISP = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_APPLY = 4'b0010,
		ST_EVAL = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	rbsr_pkg::item_t item_q;
	logic [rbsr_pkg::STEP_W-1:0] normal_step_q, scram_step_q;
	logic signed [WW-1:0] worth_q [NB];
	logic signed [WW-1:0] tip_worth_q;
	logic [rbsr_pkg::MASK_W-1:0] mask_q;
	logic [PW-1:0] pos_q [NB];
	logic [PW-1:0] tgt_q [NB];
	logic scram_q;
	logic [2:0] phase_q;
	logic [rbsr_pkg::BANK_W-1:0] bidx_q;
	logic signed [P_W-1:0] prod_q;
	logic signed [ACC_W-1:0] rho_q;
	logic [rbsr_pkg::TOTAL_W-1:0] total_q;
	logic [PW-1:0] cap_pos_q;
	logic out_valid_q;
	logic signed [rbsr_pkg::REACT_W-1:0] react_q;
	logic [rbsr_pkg::TOTAL_W-1:0] total_out_q;
	logic [PW-1:0] pos_out_q, tgt_out_q;
	logic scram_out_q;

	logic [PW-1:0] c, om, prod_hi;
	logic [PW:0] three_minus;
	logic [PW+4:0] d27;
	logic signed [A_W-1:0] mul_a;
	logic signed [B_W-1:0] mul_b;
	logic signed [ACC_W-1:0] term;
	logic [TRAV_W-1:0] travel;
	logic [PW-1:0] new_pos [NB];
	logic signed [D_W-1:0] diff [NB];
	logic signed [D_W-1:0] moved [NB];
	logic load_out;
	logic signed [ACC_W-1:0] rho_sat;

	assign c = pos_q[bidx_q];
	assign om = rbsr_pkg::ONE - c;
	assign three_minus = (PW + 1)'(3 * (1 << F)) - {c, 1'b0};
	assign prod_hi = prod_q[F +: PW];
	assign d27 = ((PW + 5)'(prod_hi) * (PW + 5)'(27)) >> 2;
	// The product is signed, so the dropped fraction bits floor towards minus infinity.
	assign term = ACC_W'($signed(prod_q[P_W-1:F]));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (phase_q)
			PH_SQ: begin
				mul_a = A_W'(c);
				mul_b = B_W'(c);
			end
			PH_SMOOTH: begin
				mul_a = A_W'(prod_hi);
				mul_b = B_W'(three_minus);
			end
			PH_WORTH: begin
				mul_a = A_W'(worth_q[bidx_q]);
				mul_b = B_W'(prod_hi);
			end
			PH_COM: begin
				mul_a = A_W'(c);
				mul_b = B_W'(om);
			end
			PH_COM2: begin
				mul_a = A_W'(prod_hi);
				mul_b = B_W'(om);
			end
			PH_TIP: begin
				mul_a = A_W'(tip_worth_q);
				mul_b = B_W'({1'b0, d27[PW:0]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Each bank moves by at most the travel, then is held inside [0, ONE].
	always_comb begin
		travel = TRAV_W'(scram_q ? scram_step_q : normal_step_q) * TRAV_W'(item_q.elapsed);
		for (int b = 0; b < NB; b++) begin
			diff[b] = D_W'(tgt_q[b]) - D_W'(pos_q[b]);
			if (diff[b] > $signed({1'b0, travel})) begin
				diff[b] = $signed({1'b0, travel});
			end else if (diff[b] < -$signed({1'b0, travel})) begin
				diff[b] = -$signed({1'b0, travel});
			end
			moved[b] = D_W'(pos_q[b]) + diff[b];
			if (moved[b] < 0) begin
				new_pos[b] = '0;
			end else if (moved[b] > D_W'(rbsr_pkg::ONE)) begin
				new_pos[b] = rbsr_pkg::ONE;
			end else begin
				new_pos[b] = moved[b][PW-1:0];
			end
		end
	end

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign rho_sat = (rho_q > R_MAX) ? R_MAX : ((rho_q < R_MIN) ? R_MIN : rho_q);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (state_q == ST_EVAL) begin
			prod_q <= P_W'(mul_a) * P_W'(mul_b);
			if (phase_q == PH_SQ && bidx_q == item_q.bank) begin
				cap_pos_q <= c;
			end
		end
		if (load_out) begin
			react_q <= rho_sat[rbsr_pkg::REACT_W-1:0];
			total_out_q <= total_q;
			pos_out_q <= cap_pos_q;
			tgt_out_q <= tgt_q[item_q.bank];
			scram_out_q <= scram_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			normal_step_q <= rbsr_pkg::STEP_W'(64);
			scram_step_q <= rbsr_pkg::STEP_W'(256);
			for (int b = 0; b < NB; b++) begin
				worth_q[b] <= '0;
			end
			tip_worth_q <= '0;
			mask_q <= '0;
			pos_q[0] <= MAN_INIT;
			pos_q[1] <= MAN_INIT;
			pos_q[2] <= HALF;
			pos_q[3] <= '0;
			tgt_q[0] <= MAN_INIT;
			tgt_q[1] <= MAN_INIT;
			tgt_q[2] <= HALF;
			tgt_q[3] <= '0;
			scram_q <= 1'b0;
			phase_q <= PH_SQ;
			bidx_q <= '0;
			rho_q <= '0;
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rbsr_pkg::REG_NORMAL_STEP: normal_step_q <= cfg_data[rbsr_pkg::STEP_W-1:0];
					rbsr_pkg::REG_SCRAM_STEP: scram_step_q <= cfg_data[rbsr_pkg::STEP_W-1:0];
					rbsr_pkg::REG_WORTH_A: worth_q[0] <= cfg_data;
					rbsr_pkg::REG_WORTH_B: worth_q[1] <= cfg_data;
					rbsr_pkg::REG_WORTH_AUTO: worth_q[2] <= cfg_data;
					rbsr_pkg::REG_WORTH_EMER: worth_q[3] <= cfg_data;
					rbsr_pkg::REG_TIP_WORTH: tip_worth_q <= cfg_data;
					rbsr_pkg::REG_DISP_MASK: mask_q <= cfg_data[rbsr_pkg::MASK_W-1:0];
					default: ;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					case (item_q.op)
						rbsr_pkg::OP_SET: begin
							if (!scram_q) begin
								tgt_q[item_q.bank] <= item_q.frac;
							end
						end
						rbsr_pkg::OP_SCRAM: begin
							scram_q <= 1'b1;
							for (int b = 0; b < NB; b++) begin
								tgt_q[b] <= rbsr_pkg::ONE;
							end
						end
						rbsr_pkg::OP_RELEASE: scram_q <= 1'b0;
						rbsr_pkg::OP_TICK: begin
							for (int b = 0; b < NB; b++) begin
								pos_q[b] <= new_pos[b];
							end
						end
						default: ;
					endcase
					phase_q <= PH_SQ;
					bidx_q <= '0;
					rho_q <= '0;
					total_q <= '0;
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (phase_q == PH_WORTH) begin
						total_q <= total_q + rbsr_pkg::TOTAL_W'(prod_hi);
					end
					if (phase_q == PH_COM) begin
						rho_q <= rho_q + term;
					end
					if (phase_q == PH_DISP) begin
						if (mask_q[bidx_q]) begin
							rho_q <= rho_q + term;
						end
						phase_q <= PH_SQ;
						bidx_q <= bidx_q + 1'b1;
						if (bidx_q == rbsr_pkg::BANK_W'(NB - 1)) begin
							state_q <= ST_DONE;
						end
					end else begin
						phase_q <= phase_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign reactivity = react_q;
	assign inserted_total = total_out_q;
	assign bank_position = pos_out_q;
	assign bank_target = tgt_out_q;
	assign scram_active = scram_out_q;

`ifndef SYNTHESIS
	a_scram_targets: assert property (@(posedge clk) disable iff (!arst_n)
		scram_q |-> (tgt_q[0] == rbsr_pkg::ONE && tgt_q[1] == rbsr_pkg::ONE &&
			tgt_q[2] == rbsr_pkg::ONE && tgt_q[3] == rbsr_pkg::ONE))
		else $error("target moved while scram latched");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q[0] <= rbsr_pkg::ONE && pos_q[1] <= rbsr_pkg::ONE &&
		pos_q[2] <= rbsr_pkg::ONE && pos_q[3] <= rbsr_pkg::ONE)
		else $error("rod position beyond full insertion");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == ST_APPLY) else $error("popped item not applied");
`endif

endmodule

FILE: hw/rtl/rod_bank_slew_and_reactivity_core.sv
// Top level of the rod bank slew and reactivity core.
// Instantiates rbsr_front (request queue) and rbsr_back (state and evaluation); uses rbsr_pkg.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  kind, bank, target_fraction, elapsed
// out       output     out_valid/out_stall  reactivity, inserted_total, bank_position,
//                                           bank_target, scram_active
// cfg       input      cfg_we               cfg_index, cfg_data
//
// Each request passes through the back end in turn: a pop, an apply step, seven multiplier
// steps on each of four banks, and a load of the output register. The shared 25 by 19 bit
// multiplier takes these steps one at a time. Reset is asynchronous and restores the rod
// state and configuration registers at once. A two-entry queue takes requests while the
// back end works, and a finished result waits in its register under stall.
module rod_bank_slew_and_reactivity_core #(
	parameter int INITIAL_MANUAL = rbsr_pkg::INITIAL_MANUAL_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [rbsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbsr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [rbsr_pkg::KIND_W-1:0] kind,
	input  logic [rbsr_pkg::BANK_W-1:0] bank,
	input  logic [rbsr_pkg::POS_W-1:0] target_fraction,
	input  logic [rbsr_pkg::ELAPSED_W-1:0] elapsed,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [rbsr_pkg::REACT_W-1:0] reactivity,
	output logic [rbsr_pkg::TOTAL_W-1:0] inserted_total,
	output logic [rbsr_pkg::POS_W-1:0] bank_position,
	output logic [rbsr_pkg::POS_W-1:0] bank_target,
	output logic scram_active
);
	logic q_valid, q_pop;
	rbsr_pkg::item_t q_item;

	rbsr_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .bank(bank), .target_fraction(target_fraction), .elapsed(elapsed),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	rbsr_back #(.INITIAL_MANUAL(INITIAL_MANUAL)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.reactivity(reactivity), .inserted_total(inserted_total),
		.bank_position(bank_position), .bank_target(bank_target),
		.scram_active(scram_active)
	);

endmodule
